>>> hw/rtl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  // Byte constants of the form-urlencoded syntax
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [7:0] MAX_OUT_RESET = 8'd31;
  localparam int SOURCE_MAX_DEFAULT = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int CONSUMED_W = 9;

  // Decoder position inside a value
  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_HI,
    PH_LO
  } phase_t;

  // Byte class found by the front end
  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_PLUS,
    CLS_PCT,
    CLS_TERM
  } byte_class_t;

  // One classified source byte as it waits in the queue
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
    logic        hex_ok;
    logic [3:0]  nibble;
  } item_t;

endpackage

>>> hw/rtl/upd_front.sv
`timescale 1ns / 1ps

module upd_front
  import upd_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output item_t      item
);

  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] nib_wide;

  // Classify the hex digit value
  always_comb begin
    is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);
    is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    if (is_digit) begin
      nib_wide = in_byte - 8'h30;
    end else if (is_lower) begin
      nib_wide = in_byte - 8'h57;
    end else if (is_upper) begin
      nib_wide = in_byte - 8'h37;
    end else begin
      nib_wide = 8'h00;
    end
  end

  // Build the queue word
  always_comb begin
    item.data   = in_byte;
    item.last   = last_byte;
    item.hex_ok = is_digit || is_lower || is_upper;
    item.nibble = nib_wide[3:0];
    if (in_byte == CHAR_SPACE || in_byte == CHAR_AMP || in_byte == CHAR_CR ||
        in_byte == CHAR_LF || in_byte == CHAR_TAB) begin
      item.cls = CLS_TERM;
    end else if (in_byte == CHAR_PCT) begin
      item.cls = CLS_PCT;
    end else if (in_byte == CHAR_PLUS) begin
      item.cls = CLS_PLUS;
    end else begin
      item.cls = CLS_PLAIN;
    end
  end

endmodule

>>> hw/rtl/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue
  import upd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == CW'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> hw/rtl/upd_back.sv
`timescale 1ns / 1ps

module upd_back
  import upd_pkg::*;
#(
  parameter int SOURCE_MAX = SOURCE_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] max_out,
  input  item_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       finished,
  output logic       failed,
  output logic [CONSUMED_W-1:0] consumed
);

  localparam int SW = $clog2(SOURCE_MAX + 1);
  localparam int XW = (SW > CONSUMED_W) ? SW : CONSUMED_W;
  localparam logic [SW-1:0] SRC_LAST = SW'(SOURCE_MAX - 1);

  phase_t          phase;
  phase_t          phase_next;
  logic [3:0]      high_nibble;
  logic [7:0]      out_count;
  logic [SW-1:0]   src_count;

  logic            src_end;
  logic [SW-1:0]   src_plus;
  logic [8:0]      out_plus;
  logic            limit_hit;
  logic            limit_full;

  logic [7:0]      r_byte;
  logic            r_valid;
  logic            r_fin;
  logic            r_fail;
  logic [SW-1:0]   r_cons;
  logic            src_inc;
  logic            out_inc;
  logic            nib_load;
  logic [XW-1:0]   cons_ext;

  // Take a word whenever the result register is free or draining
  assign pop = !empty && (!res_valid || !res_stall);

  assign src_end    = head.last || (src_count >= SRC_LAST);
  assign src_plus   = src_count + 1'b1;
  assign out_plus   = {1'b0, out_count} + 9'd1;
  assign limit_hit  = out_plus >= {1'b0, max_out};
  assign limit_full = out_count >= max_out;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HI: begin
        phase_next = (!head.hex_ok || src_end) ? PH_PLAIN : PH_LO;
      end
      PH_LO: begin
        phase_next = PH_PLAIN;
      end
      default: begin
        if (!limit_full && head.cls == CLS_PCT && !src_end) begin
          phase_next = PH_HI;
        end else begin
          phase_next = PH_PLAIN;
        end
      end
    endcase
  end

  // Result and counter updates
  always_comb begin
    r_byte   = 8'h00;
    r_valid  = 1'b0;
    r_fin    = 1'b0;
    r_fail   = 1'b0;
    r_cons   = '0;
    src_inc  = 1'b0;
    out_inc  = 1'b0;
    nib_load = 1'b0;
    unique case (phase)
      PH_HI: begin
        if (!head.hex_ok || src_end) begin
          r_fin  = 1'b1;
          r_fail = 1'b1;
        end else begin
          src_inc  = 1'b1;
          nib_load = 1'b1;
        end
      end
      PH_LO: begin
        if (!head.hex_ok) begin
          r_fin  = 1'b1;
          r_fail = 1'b1;
        end else begin
          r_byte  = {high_nibble, head.nibble};
          r_valid = 1'b1;
          src_inc = 1'b1;
          out_inc = 1'b1;
          if (src_end || limit_hit) begin
            r_fin  = 1'b1;
            r_cons = src_plus;
          end
        end
      end
      default: begin
        if (limit_full || head.cls == CLS_TERM) begin
          r_fin  = 1'b1;
          r_cons = src_count;
        end else if (head.cls == CLS_PCT) begin
          if (src_end) begin
            r_fin  = 1'b1;
            r_fail = 1'b1;
          end else begin
            src_inc = 1'b1;
          end
        end else begin
          r_byte  = (head.cls == CLS_PLUS) ? CHAR_SPACE : head.data;
          r_valid = 1'b1;
          src_inc = 1'b1;
          out_inc = 1'b1;
          if (src_end || limit_hit) begin
            r_fin  = 1'b1;
            r_cons = src_plus;
          end
        end
      end
    endcase
  end

  assign cons_ext = XW'(r_cons);

  // Advance the value state; a finish starts a new value
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      high_nibble <= 4'h0;
      out_count   <= 8'h00;
      src_count   <= '0;
    end else if (pop) begin
      if (r_fin) begin
        phase       <= PH_PLAIN;
        high_nibble <= 4'h0;
        out_count   <= 8'h00;
        src_count   <= '0;
      end else begin
        phase <= phase_next;
        if (nib_load) begin
          high_nibble <= head.nibble;
        end
        if (out_inc) begin
          out_count <= out_plus[7:0];
        end
        if (src_inc) begin
          src_count <= src_plus;
        end
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte  <= r_byte;
      out_valid <= r_valid;
      finished  <= r_fin;
      failed    <= r_fail;
      consumed  <= r_fail ? '0 : cons_ext[CONSUMED_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && failed |-> finished && !out_valid && consumed == '0)
    else $error("failed result not shaped as a finish");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    pop && r_fin |=> phase == PH_PLAIN && src_count == '0 && out_count == 8'h00)
    else $error("value state not cleared after finish");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(consumed))
    else $error("stalled result changed");
  a_src_bound: assert property (@(posedge clk) disable iff (rst)
    src_count <= SRC_LAST)
    else $error("source count beyond bound");
`endif

endmodule

>>> hw/rtl/url_percent_decoder.sv
`timescale 1ns / 1ps

// Streaming form-urlencoded value decoder. Source bytes enter on the in_valid/in_stall
// channel, one word per cycle while in_stall is low, and each one yields exactly one
// result word: the decoded byte if any, plus finished/failed flags and the consumed
// source count at a finish. Throughput is one byte per clock while res_stall is low.
// Each byte is classified combinationally and written into a two-entry queue; the decode
// state update then loads the result register from the queue head once that register is
// free or being taken. The queue lets the input keep flowing for two words while the
// result side is stalled. max_out is written on the cfg channel, which is always ready;
// write it only while no words are in flight. There is no clearing pass after reset.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int SOURCE_MAX = SOURCE_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       finished,
  output logic       failed,
  output logic [CONSUMED_W-1:0] consumed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] max_out
);

  logic [7:0] max_out_q;
  item_t      front_item;
  item_t      head;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;
  logic       q_push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  // Hold the output limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_q <= MAX_OUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_out_q <= max_out;
    end
  end

  upd_front u_front (
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .item      (front_item)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  upd_back #(
    .SOURCE_MAX (SOURCE_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_out   (max_out_q),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .finished  (finished),
    .failed    (failed),
    .consumed  (consumed)
  );

endmodule

>>> tb/tb_url_percent_decoder.sv
`timescale 1ns / 1ps

module tb_url_percent_decoder;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_WORDS = 230;

  // Receiver stall modes
  localparam int STALL_NONE = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  out_valid;
    logic                  finished;
    logic                  failed;
    logic [CONSUMED_W-1:0] consumed;
  } result_t;

  // One source word; a typed row carries its own expected result
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } src_word_t;

  localparam result_t NO_RES = '0;
  localparam result_t TERM_EMPTY = '{8'h00, 1'b0, 1'b1, 1'b0, 9'd0};
  localparam result_t BAD_ESCAPE = '{8'h00, 1'b0, 1'b1, 1'b1, 9'd0};

  // Directed rows, decoded with max_out at its reset value
  localparam int DIR_ROWS = 25;
  localparam src_word_t DIRECTED [DIR_ROWS] = '{
    '{8'h61, 1'b0, 1'b0, NO_RES},                            // 'a'
    '{CHAR_PLUS, 1'b0, 1'b0, NO_RES},
    '{CHAR_PCT, 1'b0, 1'b0, NO_RES},
    '{8'h34, 1'b0, 1'b0, NO_RES},                            // '4'
    '{8'h46, 1'b1, 1'b1, '{8'h4F, 1'b1, 1'b1, 1'b0, 9'd5}},  // 'F', escape ends source
    '{CHAR_PCT, 1'b0, 1'b0, NO_RES},
    '{8'h66, 1'b0, 1'b0, NO_RES},                            // 'f'
    '{8'h46, 1'b0, 1'b0, NO_RES},                            // 'F', mixed case
    '{CHAR_SPACE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 9'd3}},
    '{CHAR_AMP, 1'b0, 1'b1, TERM_EMPTY},
    '{CHAR_CR, 1'b0, 1'b1, TERM_EMPTY},
    '{CHAR_LF, 1'b0, 1'b1, TERM_EMPTY},
    '{CHAR_TAB, 1'b0, 1'b1, TERM_EMPTY},
    '{CHAR_PCT, 1'b1, 1'b1, BAD_ESCAPE},                     // cut off at '%'
    '{CHAR_PCT, 1'b0, 1'b0, NO_RES},
    '{8'h41, 1'b1, 1'b1, BAD_ESCAPE},                        // cut off after first digit
    '{CHAR_PCT, 1'b0, 1'b0, NO_RES},
    '{8'h67, 1'b0, 1'b1, BAD_ESCAPE},                        // 'g' as first digit
    '{CHAR_PCT, 1'b0, 1'b0, NO_RES},
    '{8'h39, 1'b0, 1'b0, NO_RES},                            // '9'
    '{8'h7A, 1'b0, 1'b1, BAD_ESCAPE},                        // 'z' as second digit
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 9'd1}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 9'd1}},
    '{CHAR_PLUS, 1'b1, 1'b1, '{CHAR_SPACE, 1'b1, 1'b1, 1'b0, 9'd1}},
    '{CHAR_TAB, 1'b1, 1'b1, TERM_EMPTY}                      // terminator beats last flag
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_valid;
  logic                  finished;
  logic                  failed;
  logic [CONSUMED_W-1:0] consumed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            max_out = MAX_OUT_RESET;

  src_word_t source_bytes[$];
  result_t   pending_results[$];
  src_word_t cur_word = '0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        stall_mode = STALL_NONE;
  int        stall_left = 0;

  // Decoder state as the block should hold it
  phase_t     dec_phase;
  logic [3:0] dec_high;
  int         dec_out_cnt;
  int         dec_src_cnt;
  logic [7:0] dec_max_out;

  url_percent_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .finished  (finished),
    .failed    (failed),
    .consumed  (consumed),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .max_out   (max_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hex digit value, bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic is_terminator(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_AMP || b == CHAR_CR || b == CHAR_LF || b == CHAR_TAB;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  // Advance the decoder by one source byte and return its result word
  function automatic result_t decode_step(logic [7:0] b, logic lst);
    result_t    r;
    logic       src_end;
    logic [4:0] nib;
    r = '0;
    src_end = lst || (dec_src_cnt + 1 >= SOURCE_MAX_DEFAULT);
    nib = hex_nibble(b);
    case (dec_phase)
      PH_HI: begin
        if (nib[4] || src_end) begin
          r.finished = 1'b1;
          r.failed = 1'b1;
        end else begin
          dec_high = nib[3:0];
          dec_src_cnt++;
          dec_phase = PH_LO;
        end
      end
      PH_LO: begin
        if (nib[4]) begin
          r.finished = 1'b1;
          r.failed = 1'b1;
        end else begin
          r.out_byte = {dec_high, nib[3:0]};
          r.out_valid = 1'b1;
          dec_src_cnt++;
          dec_out_cnt++;
          dec_phase = PH_PLAIN;
          if (src_end || dec_out_cnt >= dec_max_out) r.finished = 1'b1;
        end
      end
      default: begin
        if (dec_out_cnt >= dec_max_out || is_terminator(b)) begin
          r.finished = 1'b1;
        end else if (b == CHAR_PCT) begin
          if (src_end) begin
            r.finished = 1'b1;
            r.failed = 1'b1;
          end else begin
            dec_src_cnt++;
            dec_phase = PH_HI;
          end
        end else begin
          r.out_byte = (b == CHAR_PLUS) ? CHAR_SPACE : b;
          r.out_valid = 1'b1;
          dec_src_cnt++;
          dec_out_cnt++;
          if (src_end || dec_out_cnt >= dec_max_out) r.finished = 1'b1;
        end
      end
    endcase
    // Close the value and start a fresh one
    if (r.finished) begin
      if (!r.failed) r.consumed = CONSUMED_W'(dec_src_cnt);
      dec_phase = PH_PLAIN;
      dec_high = '0;
      dec_out_cnt = 0;
      dec_src_cnt = 0;
    end
    return r;
  endfunction

  task automatic push_byte(logic [7:0] b, logic lst);
    source_bytes.push_back('{b, lst, 1'b0, NO_RES});
  endtask

  // Queue mostly well-formed values with random content, plus broken escapes and noise
  task automatic gen_words(int count);
    int         base;
    int         n;
    int         t;
    int         sel;
    logic       ends_term;
    logic       lst;
    logic [7:0] b;
    logic [4:0] nib;
    base = source_bytes.size();
    while (source_bytes.size() - base < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 12);
        ends_term = $urandom_range(0, 1);
        for (t = 0; t < n; t++) begin
          lst = !ends_term && (t == n - 1);
          sel = $urandom_range(0, 9);
          if (sel < 3) begin
            push_byte(CHAR_PCT, 1'b0);
            push_byte(hex_char(4'($urandom)), 1'b0);
            push_byte(hex_char(4'($urandom)), lst);
          end else if (sel == 3) begin
            push_byte(CHAR_PLUS, lst);
          end else begin
            do b = 8'($urandom); while (is_terminator(b) || b == CHAR_PCT);
            push_byte(b, lst);
          end
        end
        if (ends_term) begin
          case ($urandom_range(0, 4))
            0: b = CHAR_SPACE;
            1: b = CHAR_AMP;
            2: b = CHAR_CR;
            3: b = CHAR_LF;
            default: b = CHAR_TAB;
          endcase
          push_byte(b, $urandom_range(0, 3) == 0);
        end
      end else if (sel == 8) begin
        // Broken escape: cut off, or a bad digit in either place
        sel = $urandom_range(0, 3);
        push_byte(CHAR_PCT, sel == 0);
        if (sel != 0) begin
          do begin
            b = 8'($urandom);
            nib = hex_nibble(b);
          end while (!nib[4]);
          if (sel == 1) begin
            push_byte(b, 1'b0);
          end else begin
            push_byte(hex_char(4'($urandom)), sel == 2);
            if (sel == 3) push_byte(b, 1'b0);
          end
        end
      end else begin
        push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Send queued words in bursts with random gaps between them
  task automatic drive_words();
    int   burst;
    int   gap;
    logic drain;
    while (source_bytes.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && source_bytes.size() != 0) begin
        @(negedge clk);
        cur_word = source_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte <= cur_word.data;
        last_byte <= cur_word.last;
        do @(posedge clk); while (in_stall);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      drain = ($urandom_range(0, 40) == 0);
      if (gap != 0 || drain) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        // Hold off until the block has returned every word
        if (drain) while (pending_results.size() != 0) @(posedge clk);
      end
    end
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_out(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    max_out <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Stall the result side in none, light or heavy mode, with the mode drawn anew at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Predict accepted words and check returned words
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      dec_phase = PH_PLAIN;
      dec_high = '0;
      dec_out_cnt = 0;
      dec_src_cnt = 0;
      dec_max_out = MAX_OUT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) dec_max_out = max_out;
      if (res_valid && !res_stall) begin
        got = '{out_byte, out_valid, finished, failed, consumed};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: result word with nothing pending: %h %b %b %b %0d",
                     $time, got.out_byte, got.out_valid, got.finished, got.failed, got.consumed);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("%0t: mismatch: expected %h %b %b %b %0d, got %h %b %b %b %0d", $time,
                       want.out_byte, want.out_valid, want.finished, want.failed, want.consumed,
                       got.out_byte, got.out_valid, got.finished, got.failed, got.consumed);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = decode_step(cur_word.data, cur_word.last);
        pending_results.push_back(cur_word.typed ? cur_word.want : want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int phase_max [6];
    int k;
    phase_max = '{1, 255, 5, 0, 255, 128};
    phase_max[3] = $urandom_range(2, 254);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed rows at the reset limit
    for (k = 0; k < DIR_ROWS; k++) source_bytes.push_back(DIRECTED[k]);
    drive_words();
    wait_idle();

    // Lower the limit below the bytes already produced in an open value
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b0);
    drive_words();
    wait_idle();
    write_max_out(8'd2);
    push_byte(8'h64, 1'b0);
    drive_words();
    wait_idle();

    // Random phases over a range of limits
    for (k = 0; k < 6; k++) begin
      write_max_out(8'(phase_max[k]));
      gen_words(PHASE_WORDS);
      drive_words();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_front.sv
hw/rtl/upd_queue.sv
hw/rtl/upd_back.sv
hw/rtl/url_percent_decoder.sv
tb/tb_url_percent_decoder.sv
